>>> src/hex_to_packed_bcd_converter_unit_defines.svh
// assertion macros for the hex to packed bcd converter checker
// no dependencies; included by the checker file only
`ifndef HEX_TO_PACKED_BCD_CONVERTER_UNIT_DEFINES_SVH
`define HEX_TO_PACKED_BCD_CONVERTER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HBCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hbcd assertion failed");

// next-cycle implication, disabled during reset
`define HBCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hbcd assertion failed");

`endif

>>> src/hbcd_pkg.sv
// shared types, constants and digit arithmetic for the hex to packed bcd converter
// no dependencies
package hbcd_pkg;

  localparam int unsigned DIGITS_DEF = 16;
  localparam int unsigned BCD_W      = 64;

  typedef struct packed {
    logic load;     // transaction accepted: clear carries
    logic clear;    // start of a new number: clear digits too
    logic step;     // this cell's turn in the carry ripple
    logic rad_one;  // radix digit after clear
  } cell_ctrl_t;

  typedef struct packed {
    logic [3:0] quo;
    logic [3:0] rem;
  } digit_split_t;

  // t / 10 and t % 10 for t below 160, reciprocal multiply
  function automatic digit_split_t div10(input logic [7:0] t);
    logic [15:0]  m;
    digit_split_t s;
    m     = 16'(t) * 16'd205;
    s.quo = m[14:11];
    s.rem = 4'(t - 8'(s.quo) * 8'd10);
    return s;
  endfunction

endpackage

>>> src/hbcd_if.sv
// channel interfaces for the hex to packed bcd converter
// depends on hbcd_pkg
interface hbcd_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] hex_digit;
  logic       first;
  logic       last;

  modport source (output valid, output hex_digit, output first, output last, input ready);
  modport sink   (input valid, input hex_digit, input first, input last, output ready);
endinterface

interface hbcd_out_if;
  logic                       valid;
  logic                       ready;
  logic [hbcd_pkg::BCD_W-1:0] bcd_value;
  logic                       overflow;

  modport source (output valid, output bcd_value, output overflow, input ready);
  modport sink   (input valid, input bcd_value, input overflow, output ready);
endinterface

>>> src/hbcd_cell.sv
// one decimal digit of the accumulator and of the radix, with its carry registers
// depends on hbcd_pkg
module hbcd_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hbcd_pkg::cell_ctrl_t ctrl,
  input  logic [3:0]           hex_digit,
  input  logic [3:0]           acc_cin,
  input  logic [3:0]           rad_cin,
  output logic [3:0]           acc_digit,
  output logic [3:0]           rad_digit,
  output logic [3:0]           acc_cout,
  output logic [3:0]           rad_cout
);

  logic [3:0] acc_r, acc_nxt;
  logic [3:0] rad_r, rad_nxt;
  logic [3:0] acc_c_r, acc_c_nxt;
  logic [3:0] rad_c_r, rad_c_nxt;

  logic [7:0]             acc_sum;
  logic [7:0]             rad_sum;
  hbcd_pkg::digit_split_t acc_split;
  hbcd_pkg::digit_split_t rad_split;

  always_comb begin
    // radix digit times hex digit plus accumulator digit plus carry, at most 159
    acc_sum   = 8'(rad_r * hex_digit) + {4'b0, acc_r} + {4'b0, acc_cin};
    // radix digit times sixteen plus carry
    rad_sum   = {rad_r, rad_cin};
    acc_split = hbcd_pkg::div10(acc_sum);
    rad_split = hbcd_pkg::div10(rad_sum);

    acc_nxt   = acc_r;
    rad_nxt   = rad_r;
    acc_c_nxt = acc_c_r;
    rad_c_nxt = rad_c_r;
    if (ctrl.load) begin
      acc_c_nxt = '0;
      rad_c_nxt = '0;
      if (ctrl.clear) begin
        acc_nxt = '0;
        rad_nxt = {3'b0, ctrl.rad_one};
      end
    end else if (ctrl.step) begin
      acc_nxt   = acc_split.rem;
      rad_nxt   = rad_split.rem;
      acc_c_nxt = acc_split.quo;
      rad_c_nxt = rad_split.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      rad_r   <= {3'b0, ctrl.rad_one};
      acc_c_r <= '0;
      rad_c_r <= '0;
    end else begin
      acc_r   <= acc_nxt;
      rad_r   <= rad_nxt;
      acc_c_r <= acc_c_nxt;
      rad_c_r <= rad_c_nxt;
    end
  end

  assign acc_digit = acc_r;
  assign rad_digit = rad_r;
  assign acc_cout  = acc_c_r;
  assign rad_cout  = rad_c_r;

endmodule

>>> src/hex_to_packed_bcd_converter_unit.sv
// hex to packed bcd converter: a row of DIGITS decimal cells, carries ripple one cell per cycle
// the input takes a new digit only once the carries of the last one have rippled through every cell;
//   a last digit then waits in an emit state until the output register is free (no result held
//   or the held one taken), loads the result there with out valid raised, and keeps the input busy until then
// reset: synchronous active-low rst_n; accumulator 0, radix one, overflow clear, channels idle
// depends on hbcd_pkg, hbcd_if and hbcd_cell
module hex_to_packed_bcd_converter_unit #(
  parameter int unsigned DIGITS = hbcd_pkg::DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  hbcd_in_if.sink           in_ch,
  hbcd_out_if.source        out_ch
);

  localparam int unsigned STEP_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [3:0]        digit_r, digit_nxt;
  logic              last_r, last_nxt;
  logic              ovf_seen_r, ovf_seen_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [hbcd_pkg::BCD_W-1:0] out_bcd_r, out_bcd_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              accept;
  logic              ovf_now;
  logic [hbcd_pkg::BCD_W-1:0] bcd_all;

  hbcd_pkg::cell_ctrl_t ctrl [DIGITS];
  logic [3:0] acc_digit [DIGITS];
  logic [3:0] rad_digit [DIGITS];
  logic [3:0] acc_cout  [DIGITS];
  logic [3:0] rad_cout  [DIGITS];

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  genvar gi;
  generate
    for (gi = 0; gi < DIGITS; gi++) begin : g_cell
      logic [3:0] acc_cin;
      logic [3:0] rad_cin;

      if (gi == 0) begin : g_low
        assign acc_cin = '0;
        assign rad_cin = '0;
      end else begin : g_up
        assign acc_cin = acc_cout[gi-1];
        assign rad_cin = rad_cout[gi-1];
      end

      assign ctrl[gi].load    = accept;
      assign ctrl[gi].clear   = accept && in_ch.first;
      assign ctrl[gi].step    = (state_r == ST_RUN) && (step_r == STEP_W'(gi));
      assign ctrl[gi].rad_one = (gi == 0);

      hbcd_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl[gi]),
        .hex_digit (digit_r),
        .acc_cin   (acc_cin),
        .rad_cin   (rad_cin),
        .acc_digit (acc_digit[gi]),
        .rad_digit (rad_digit[gi]),
        .acc_cout  (acc_cout[gi]),
        .rad_cout  (rad_cout[gi])
      );
    end
  endgenerate

  // top carry register holds the last run's carry out until the next transaction clears it
  assign ovf_now = ovf_seen_r || (acc_cout[DIGITS-1] != 4'd0);

  always_comb begin
    bcd_all = '0;
    for (int i = 0; i < DIGITS; i++) begin
      bcd_all[4*i +: 4] = acc_digit[i];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    digit_nxt     = digit_r;
    last_nxt      = last_r;
    ovf_seen_nxt  = ovf_seen_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_bcd_nxt   = out_bcd_r;
    out_ovf_nxt   = out_ovf_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          digit_nxt    = in_ch.hex_digit;
          last_nxt     = in_ch.last;
          ovf_seen_nxt = in_ch.first ? 1'b0 : ovf_now;
          step_nxt     = '0;
          state_nxt    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_r == STEP_W'(DIGITS - 1)) begin
          step_nxt  = '0;
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_bcd_nxt   = bcd_all;
          out_ovf_nxt   = ovf_now;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      last_r      <= 1'b0;
      ovf_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      last_r      <= last_nxt;
      ovf_seen_r  <= ovf_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digit_r   <= digit_nxt;
    out_bcd_r <= out_bcd_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.bcd_value = out_bcd_r;
  assign out_ch.overflow  = out_ovf_r;

endmodule

>>> src/hbcd_checker.sv
// port-level checker for the hex to packed bcd converter, bound to the top level
// depends on hbcd_pkg and hex_to_packed_bcd_converter_unit_defines.svh
`include "hex_to_packed_bcd_converter_unit_defines.svh"

module hbcd_checker #(
  parameter int unsigned DIGITS = hbcd_pkg::DIGITS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [hbcd_pkg::BCD_W-1:0] out_bcd,
  input logic                       out_overflow
);

  // every used nibble a decimal digit, everything above the used digits zero
  function automatic logic bcd_ok(input logic [hbcd_pkg::BCD_W-1:0] v);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < hbcd_pkg::BCD_W / 4; i++) begin
      if (i < DIGITS) begin
        if (v[4*i +: 4] > 4'd9) ok = 1'b0;
      end else begin
        if (v[4*i +: 4] != 4'd0) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // the cell row is busy after a transaction
  `HBCD_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `HBCD_ASSERT_IMP(a_out_is_bcd, clk, rst_n, out_valid, bcd_ok(out_bcd))
  `HBCD_ASSERT_NXT(a_out_held, clk, rst_n, out_valid && !out_ready, out_valid)
  `HBCD_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_bcd) && $stable(out_overflow))

endmodule

bind hex_to_packed_bcd_converter_unit hbcd_checker #(.DIGITS(DIGITS)) u_hbcd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_bcd      (out_ch.bcd_value),
  .out_overflow (out_ch.overflow)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// testbench for hex_to_packed_bcd_converter_unit: random and directed hex digit streams,
// predicted packed bcd results checked against the output channel in order
// depends on hbcd_pkg, hbcd_if and the converter rtl
module testbench;

  localparam int unsigned BCD_W        = hbcd_pkg::BCD_W;
  localparam int unsigned DIGITS       = hbcd_pkg::DIGITS_DEF;
  localparam int unsigned HOLD_LEN     = 400;
  localparam int unsigned DRAIN_CYCLES = 2 * (DIGITS + 2);
  localparam int unsigned PHASE_ITEMS  = 270;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [3:0] digit;
    logic       first;
    logic       last;
  } hex_xact_t;

  typedef struct packed {
    logic [BCD_W-1:0] bcd_value;
    logic             overflow;
  } bcd_result_t;

  logic clk;
  logic rst_n;

  hbcd_in_if  in_ch ();
  hbcd_out_if out_ch ();

  hex_to_packed_bcd_converter_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hex_xact_t   digit_q[$];
  bcd_result_t bcd_expect_q[$];
  bcd_result_t r_left;

  // predictor state, matches the block right after reset
  logic [BCD_W-1:0] acc_bcd   = '0;
  logic [BCD_W-1:0] radix_bcd = BCD_W'(1);
  logic             ovf_seen  = 1'b0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned digits_taken   = 0;
  int unsigned results_seen   = 0;
  int unsigned ovf_results    = 0;
  int unsigned queued_items   = 0;

  logic        hold_go     = 1'b0;
  logic        hold_done   = 1'b0;
  int unsigned hold_cycles = 0;
  logic        hold_active;

  assign hold_active = hold_go && !hold_done;

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.hex_digit = '0;
    in_ch.first  = 1'b0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // acc + rad * d digit by digit with decimal carries
  function automatic logic [BCD_W-1:0] bcd_mul_add(input logic [BCD_W-1:0] acc,
                                                   input logic [BCD_W-1:0] rad,
                                                   input logic [3:0] d,
                                                   output logic carry_out);
    logic [BCD_W-1:0] res;
    int unsigned      c;
    int unsigned      t;
    res = '0;
    c   = 0;
    for (int i = 0; i < DIGITS; i++) begin
      t = rad[4*i +: 4] * d + acc[4*i +: 4] + c;
      c = t / 10;
      res[4*i +: 4] = 4'(t % 10);
    end
    carry_out = (c != 0);
    return res;
  endfunction

  // radix * 16, carry out of the top digit is dropped
  function automatic logic [BCD_W-1:0] bcd_times16(input logic [BCD_W-1:0] rad);
    logic [BCD_W-1:0] res;
    int unsigned      c;
    int unsigned      t;
    res = '0;
    c   = 0;
    for (int i = 0; i < DIGITS; i++) begin
      t = rad[4*i +: 4] * 16 + c;
      c = t / 10;
      res[4*i +: 4] = 4'(t % 10);
    end
    return res;
  endfunction

  task automatic accumulate_digit(input hex_xact_t x);
    logic        carry;
    bcd_result_t r;
    if (x.first) begin
      acc_bcd   = '0;
      radix_bcd = BCD_W'(1);
      ovf_seen  = 1'b0;
    end
    acc_bcd = bcd_mul_add(acc_bcd, radix_bcd, x.digit, carry);
    if (carry) ovf_seen = 1'b1;
    radix_bcd = bcd_times16(radix_bcd);
    if (x.last) begin
      r.bcd_value = acc_bcd;
      r.overflow  = ovf_seen;
      bcd_expect_q.push_back(r);
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [BCD_W-1:0] exp_v,
                               input logic [BCD_W-1:0] act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s expected %h got %h", $realtime, what, exp_v, act_v);
  endtask

  // long receiver hold-off, counted here so the sender keeps pushing meanwhile
  always @(posedge clk) begin
    if (hold_active) begin
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles == HOLD_LEN - 1) hold_done <= 1'b1;
    end
  end

  // driver: predicts on each accepted transaction, then offers the next one
  always @(posedge clk) begin : drive
    hex_xact_t x;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        x.digit = in_ch.hex_digit;
        x.first = in_ch.first;
        x.last  = in_ch.last;
        accumulate_digit(x);
        digits_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (digit_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          x = digit_q.pop_front();
          in_ch.hex_digit <= x.digit;
          in_ch.first     <= x.first;
          in_ch.last      <= x.last;
          in_ch.valid     <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transaction against the oldest prediction
  always @(posedge clk) begin : watch
    bcd_result_t r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (out_ch.overflow) ovf_results++;
        if (bcd_expect_q.size() == 0) begin
          flag_mismatch("unexpected result", '0, out_ch.bcd_value);
        end else begin
          r = bcd_expect_q.pop_front();
          if (out_ch.bcd_value !== r.bcd_value)
            flag_mismatch("bcd_value", r.bcd_value, out_ch.bcd_value);
          if (out_ch.overflow !== r.overflow)
            flag_mismatch("overflow", BCD_W'(r.overflow), BCD_W'(out_ch.overflow));
        end
      end
      out_ch.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_digit(input logic [3:0] d, input logic f, input logic l);
    hex_xact_t x;
    x.digit = d;
    x.first = f;
    x.last  = l;
    digit_q.push_back(x);
    queued_items++;
  endtask

  // mostly well-formed numbers; some runs of all-f digits to overflow,
  // some with random flags, some that never see last
  task automatic queue_number();
    int unsigned kind;
    int unsigned len;
    logic [3:0]  d;
    kind = $urandom_range(19);
    len  = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
    if (kind == 2) len = $urandom_range(20, 15);
    for (int i = 0; i < len; i++) begin
      d = (kind == 2) ? 4'hf : 4'($urandom_range(15));
      if (kind == 0)
        push_digit(d, 1'($urandom_range(1)), 1'($urandom_range(1)));
      else
        push_digit(d, i == 0, (i == len - 1) && (kind != 1));
    end
  endtask

  task automatic wait_quiet();
    while (digit_q.size() != 0 || in_ch.valid || bcd_expect_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input logic long_hold);
    int unsigned start;
    send_idle_pct  <= idle_pct;
    recv_stall_pct <= stall_pct;
    start = queued_items;
    while (queued_items - start < PHASE_ITEMS) queue_number();
    if (long_hold) hold_go <= 1'b1;
    wait_quiet();
    @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // no first after reset, then continuing past a last
    push_digit(4'h5, 1'b0, 1'b1);
    push_digit(4'h3, 1'b0, 1'b1);
    // single-digit numbers at both ends
    push_digit(4'h0, 1'b1, 1'b1);
    push_digit(4'hf, 1'b1, 1'b1);
    // sixteen f digits: value overflows and the radix wraps
    for (int i = 0; i < 16; i++) push_digit(4'hf, i == 0, i == 15);

    run_phase(0, 0, 1'b1);
    run_phase(50, 0, 1'b0);
    run_phase(0, 50, 1'b0);
    run_phase(7, 7, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    while (bcd_expect_q.size() != 0) begin
      r_left = bcd_expect_q.pop_front();
      flag_mismatch("missing result", r_left.bcd_value, '0);
    end
    $display("sent %0d hex digits, checked %0d bcd results (%0d flagged overflow)",
             digits_taken, results_seen, ovf_results);
    $display("idle mixes: none, sender 50%%, receiver 50%%, both 7%%, plus a %0d-cycle hold",
             HOLD_LEN);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
